### design/circular_double_ended_queue_core_defines.svh
// Assertion macros for the deque core design file.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: whenever a holds, c must hold too.
`define CDQ_ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("deque assertion failed");

// Next-cycle implication: whenever a holds, c must hold in the next cycle.
`define CDQ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("deque assertion failed");

// Condition that must never be seen.
`define CDQ_ASSERT_NEVER(label, clk, rst, a) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("deque assertion failed");

`else

`define CDQ_ASSERT_IMPLIES(label, clk, rst, a, c)
`define CDQ_ASSERT_NEXT(label, clk, rst, a, c)
`define CDQ_ASSERT_NEVER(label, clk, rst, a)

`endif

`endif

### design/cdq_pkg.sv
package cdq_pkg;

  // Command codes
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_BACK   = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Word returned by a pop from an empty queue
  localparam logic signed [31:0] POP_EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] push_value;
  } cdq_req_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic               is_full;
    logic               is_empty;
  } cdq_rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_RDWAIT
  } cdq_state_t;

endpackage

### design/circular_double_ended_queue_core.sv
// Circular double-ended queue of signed 32-bit words, DEPTH entries deep.
// Requests arrive on cmd (valid/ready) carrying a command and a push word;
// every request gives exactly one response on res (valid/ready) with the
// popped word, a status code and the full/empty flags after the request.
// Push front/back writes the slot RAM in the accepting cycle; the response
// is registered and shows in the cycle after acceptance. A push into a full
// queue answers with full status and changes nothing.
// Pop front/back reads the slot RAM through its registered read port; the
// word then passes ST_RDWAIT into the response register. A pop from an
// empty queue answers without a RAM read, with -1 and empty status.
// Throughput: one push or refused pop per cycle while responses are taken;
// a pop holds cmd_ready low in ST_RDWAIT until the RAM read returns.
// A new request is taken while a finished response waits, provided that
// response is being taken in the same cycle; if the receiver stalls, the
// response is held in the output register and cmd_ready stays low.
// Reset empties the queue (pointers and count to zero) and drops any
// pending response; slot contents are not cleared.
module circular_double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cdq_pkg::cdq_req_t cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output cdq_pkg::cdq_rsp_t res
);

  import cdq_pkg::*;

`include "circular_double_ended_queue_core_defines.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(DEPTH);

  cdq_state_t       state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [OCC_W-1:0] occupancy, occupancy_next;
  logic             res_valid_next;
  cdq_rsp_t         res_next;

  logic             accept;
  logic             is_push;
  logic             is_front;
  logic             q_full;
  logic             q_empty;
  logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  // Slot storage
  cdq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Wrapping pointer neighbours and queue flags
  assign head_inc = (head == PTR_LAST) ? '0 : head + PTR_W'(1);
  assign head_dec = (head == '0) ? PTR_LAST : head - PTR_W'(1);
  assign tail_inc = (tail == PTR_LAST) ? '0 : tail + PTR_W'(1);
  assign tail_dec = (tail == '0) ? PTR_LAST : tail - PTR_W'(1);
  assign q_full   = (occupancy == OCC_FULL);
  assign q_empty  = (occupancy == '0);
  assign is_push  = (cmd.command == CMD_PUSH_FRONT) || (cmd.command == CMD_PUSH_BACK);
  assign is_front = (cmd.command == CMD_PUSH_FRONT) || (cmd.command == CMD_POP_FRONT);

  // Request taken only in ST_IDLE and when the output register is free this cycle
  assign cmd_ready = (state == ST_IDLE) && (!res_valid || res_ready);
  assign accept    = cmd_valid && cmd_ready;

  // State register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      occupancy <= occupancy_next;
      res_valid <= res_valid_next;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // Next state, pointer update and RAM control
  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    occupancy_next = occupancy;
    res_valid_next = res_valid && !res_ready;
    res_next       = res;
    ram_we         = 1'b0;
    ram_waddr      = tail;
    ram_re         = 1'b0;
    ram_raddr      = head;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_push) begin
            res_valid_next     = 1'b1;
            res_next.pop_value = '0;
            if (q_full) begin
              res_next.status   = STAT_FULL;
              res_next.is_full  = 1'b1;
              res_next.is_empty = 1'b0;
            end else begin
              ram_we         = 1'b1;
              occupancy_next = occupancy + OCC_W'(1);
              if (is_front) begin
                ram_waddr = head_dec;
                head_next = head_dec;
              end else begin
                ram_waddr = tail;
                tail_next = tail_inc;
              end
              res_next.status   = STAT_DONE;
              res_next.is_full  = (occupancy + OCC_W'(1) == OCC_FULL);
              res_next.is_empty = 1'b0;
            end
          end else if (q_empty) begin
            res_valid_next     = 1'b1;
            res_next.pop_value = POP_EMPTY_VALUE;
            res_next.status    = STAT_EMPTY;
            res_next.is_full   = 1'b0;
            res_next.is_empty  = 1'b1;
          end else begin
            // Pop: flags now, word once the RAM read returns
            ram_re         = 1'b1;
            occupancy_next = occupancy - OCC_W'(1);
            if (is_front) begin
              ram_raddr = head;
              head_next = head_inc;
            end else begin
              ram_raddr = tail_dec;
              tail_next = tail_dec;
            end
            res_next.status   = STAT_DONE;
            res_next.is_full  = 1'b0;
            res_next.is_empty = (occupancy == OCC_W'(1));
            state_next        = ST_RDWAIT;
          end
        end
      end
      ST_RDWAIT: begin
        res_next.pop_value = ram_rdata;
        res_valid_next     = 1'b1;
        state_next         = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Checks
  `CDQ_ASSERT_NEVER(a_occ_bound, clk, rst, occupancy > OCC_FULL)
  `CDQ_ASSERT_IMPLIES(a_no_overwrite, clk, rst, accept, !res_valid || res_ready)
  `CDQ_ASSERT_NEXT(a_pop_answers, clk, rst, state == ST_RDWAIT, res_valid && state == ST_IDLE)
  `CDQ_ASSERT_IMPLIES(a_flags_excl, clk, rst, res_valid, !(res.is_full && res.is_empty))

endmodule

### design/cdq_ram.sv
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
